>>> rtl/core/fbp_pkg.sv
// Shared types and constants of the feedback frame parser.
package fbp_pkg;

  localparam logic [7:0] HEADER_BYTE   = 8'h7B;
  localparam logic [7:0] TRAILER_BYTE  = 8'h7D;
  localparam int         FRAME_LEN     = 24;
  localparam int         CHECK_SPAN    = 22;
  localparam int         PAYLOAD_BYTES = CHECK_SPAN - 1;
  localparam int         PAYLOAD_W     = PAYLOAD_BYTES * 8;
  localparam int         POS_W         = 5;

  typedef enum logic [1:0] {
    STATUS_GOOD        = 2'd0,
    STATUS_BAD_TRAILER = 2'd1,
    STATUS_BAD_CHECK   = 2'd2
  } status_t;

  typedef struct packed {
    status_t                status;
    logic [PAYLOAD_W-1:0]   payload;
  } frame_rec_t;

  typedef struct packed {
    logic       valid;
    frame_rec_t rec;
  } frame_push_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

endpackage

>>> rtl/core/fbp_byte_if.sv
// Handshake channel that carries one received serial byte.
interface fbp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

>>> rtl/core/fbp_result_if.sv
// Handshake channel that carries one decoded feedback frame result.
interface fbp_result_if;
  logic               valid;
  logic               ready;
  logic [1:0]         frame_status;
  logic               stop_flag;
  logic signed [15:0] vel_x;
  logic signed [15:0] vel_y;
  logic signed [15:0] vel_z;
  logic signed [15:0] accel_x;
  logic signed [15:0] accel_y;
  logic signed [15:0] accel_z;
  logic signed [15:0] rate_x;
  logic signed [15:0] rate_y;
  logic signed [15:0] rate_z;
  logic [15:0]        battery_mv;

  modport source (
    output valid, frame_status, stop_flag, vel_x, vel_y, vel_z,
    output accel_x, accel_y, accel_z, rate_x, rate_y, rate_z, battery_mv,
    input ready
  );
  modport sink (
    input valid, frame_status, stop_flag, vel_x, vel_y, vel_z,
    input accel_x, accel_y, accel_z, rate_x, rate_y, rate_z, battery_mv,
    output ready
  );
endinterface

>>> rtl/core/fbp_front.sv
// Front part: header hunt, byte collection, XOR check and frame classification.
module fbp_front import fbp_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  fbp_byte_if.sink       rx,
  input  queue_stat_t    qstat,
  output frame_push_t    push
);

  logic                 in_frame;
  logic [POS_W-1:0]     byte_position;
  logic [7:0]           running_check;
  logic [7:0]           check_byte;
  logic [PAYLOAD_W-1:0] payload;
  logic                 last_byte;
  logic                 take;
  status_t              status_next;

  assign last_byte = in_frame && (byte_position == POS_W'(FRAME_LEN - 1));
  assign rx.ready  = !(last_byte && qstat.full);
  assign take      = rx.valid && rx.ready;

  always_comb begin
    if (rx.rx_byte != TRAILER_BYTE) begin
      status_next = STATUS_BAD_TRAILER;
    end else if (running_check != check_byte) begin
      status_next = STATUS_BAD_CHECK;
    end else begin
      status_next = STATUS_GOOD;
    end
    push.valid          = take && last_byte;
    push.rec.status     = status_next;
    push.rec.payload    = payload;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame      <= 1'b0;
      byte_position <= '0;
      running_check <= '0;
    end else if (take) begin
      if (!in_frame) begin
        if (rx.rx_byte == HEADER_BYTE) begin
          in_frame      <= 1'b1;
          byte_position <= POS_W'(1);
          running_check <= rx.rx_byte;
        end
      end else if (byte_position >= POS_W'(FRAME_LEN)) begin
        in_frame      <= 1'b0;
        byte_position <= '0;
        running_check <= '0;
      end else if (last_byte) begin
        in_frame      <= 1'b0;
        byte_position <= '0;
        running_check <= '0;
      end else begin
        byte_position <= byte_position + POS_W'(1);
        if (byte_position < POS_W'(CHECK_SPAN)) begin
          running_check <= running_check ^ rx.rx_byte;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && in_frame) begin
      if (byte_position >= POS_W'(1) && byte_position < POS_W'(CHECK_SPAN)) begin
        payload <= {payload[PAYLOAD_W-9:0], rx.rx_byte};
      end
      if (byte_position == POS_W'(CHECK_SPAN)) begin
        check_byte <= rx.rx_byte;
      end
    end
  end

endmodule

>>> rtl/core/fbp_queue.sv
// Two-entry queue of classified frames between the front and back parts.
module fbp_queue import fbp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  frame_push_t push,
  input  logic        pop,
  output frame_rec_t  head,
  output queue_stat_t qstat
);

  frame_rec_t entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign qstat.full  = (count == 2'd2);
  assign qstat.empty = (count == 2'd0);
  assign do_push     = push.valid && !qstat.full;
  assign do_pop      = pop && !qstat.empty;
  assign head        = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (do_push && !do_pop) begin
        count <= count + 2'd1;
      end else if (do_pop && !do_push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push.rec;
    end
  end

endmodule

>>> rtl/core/fbp_back.sv
// Back part: decodes a classified frame into the registered result item.
module fbp_back import fbp_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  frame_rec_t   head,
  input  queue_stat_t  qstat,
  output logic         pop,
  fbp_result_if.source res
);

  logic good;

  function automatic logic [15:0] word_at(input logic [PAYLOAD_W-1:0] p, input int k);
    logic [15:0] w;
    w = p[PAYLOAD_W - 9 - 16 * k -: 16];
    return w;
  endfunction

  assign pop  = !qstat.empty && (!res.valid || res.ready);
  assign good = (head.status == STATUS_GOOD);

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (pop) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      res.frame_status  <= head.status;
      res.stop_flag     <= good && (head.payload[PAYLOAD_W-1 -: 8] != 8'd0);
      res.vel_x         <= good ? word_at(head.payload, 0) : 16'd0;
      res.vel_y         <= good ? word_at(head.payload, 1) : 16'd0;
      res.vel_z         <= good ? word_at(head.payload, 2) : 16'd0;
      res.accel_x       <= good ? word_at(head.payload, 3) : 16'd0;
      res.accel_y       <= good ? word_at(head.payload, 4) : 16'd0;
      res.accel_z       <= good ? word_at(head.payload, 5) : 16'd0;
      res.rate_x        <= good ? word_at(head.payload, 6) : 16'd0;
      res.rate_y        <= good ? word_at(head.payload, 7) : 16'd0;
      res.rate_z        <= good ? word_at(head.payload, 8) : 16'd0;
      res.battery_mv    <= good ? word_at(head.payload, 9) : 16'd0;
    end
  end

endmodule

>>> rtl/core/feedback_frame_parser.sv
// Feedback frame parser: serial bytes in, one decoded result per 24-byte frame out.
//
// The rx channel takes one received byte per item and accepts one byte every
// cycle unless a frame's last byte meets a full queue. While hunting, bytes
// other than the 0x7B header are dropped. After the header the next 23 bytes
// are collected without a new hunt; the 24th byte ends the frame and one
// result item leaves on the res channel, through the queue and output register.
// Its status tells a good frame, a bad trailer or a checksum mismatch; the
// decoded fields are zero unless the frame is good.
// A two-entry frame queue separates byte collection from result decoding, so
// a stalled receiver on res does not stop byte intake until the queue and the
// output register are both full; only the last byte of a frame waits then.
// Reset (synchronous, active high) returns the parser to hunting and empties
// the queue and the output register.
module feedback_frame_parser import fbp_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  fbp_byte_if.sink     rx,
  fbp_result_if.source res
);

  frame_push_t push;
  frame_rec_t  head;
  queue_stat_t qstat;
  logic        pop;

  fbp_front u_front (
    .clk   (clk),
    .rst   (rst),
    .rx    (rx),
    .qstat (qstat),
    .push  (push)
  );

  fbp_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .pop   (pop),
    .head  (head),
    .qstat (qstat)
  );

  fbp_back u_back (
    .clk   (clk),
    .rst   (rst),
    .head  (head),
    .qstat (qstat),
    .pop   (pop),
    .res   (res)
  );

`ifndef ASSERT_OFF
  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    push.valid |-> !qstat.full)
    else $error("Frame pushed into a full queue.");

  a_bad_frame_zeroed: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.frame_status != STATUS_GOOD) |->
      (!res.stop_flag && res.vel_x == 16'd0 && res.battery_mv == 16'd0))
    else $error("Fields of a rejected frame are not zero.");

  a_pop_loads_output: assert property (@(posedge clk) disable iff (rst)
    pop |=> res.valid)
    else $error("Popped frame did not reach the output register.");
`endif

endmodule
